// ----- hdl/sfcp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcp_pkg
// Shared types, constants and the crc byte fold for the frame packer.
// ----------------------------------------------------------------------------
package sfcp_pkg;

    // frame and crc constants
    localparam int          CHANNELS_DEF = 4;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one classified sample on its way to the back end
    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_item;

    // queue status seen by front, back and top
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    // byte phases of the back end sequencer
    typedef enum logic [3:0] {
        PH_LO     = 4'b0001,
        PH_HI     = 4'b0010,
        PH_CRC_LO = 4'b0100,
        PH_CRC_HI = 4'b1000
    } t_phase;

    // fold one byte into a reflected crc-16, one bit per step
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/sfcp_front.sv -----
// ----------------------------------------------------------------------------
// sfcp_front
// Accepts samples, counts them within the frame and marks the last one.
// ----------------------------------------------------------------------------
module sfcp_front #(
    parameter int CHANNELS = sfcp_pkg::CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [15:0]         i_sample,
    input  sfcp_pkg::t_q_status i_q_status,
    output logic                o_full,
    output logic                o_q_push,
    output sfcp_pkg::t_item     o_q_item
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W:0] LAST_IDX = (IDX_W + 1)'(CHANNELS - 1);

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             last;
    logic             xfer;

    // input transfer whenever the queue has room
    assign o_full   = i_q_status.full;
    assign xfer     = i_push && !i_q_status.full;
    assign o_q_push = xfer;

    // classify: at or past the last channel closes the frame
    assign last = ({1'b0, r_idx} >= LAST_IDX);

    assign o_q_item.sample = i_sample;
    assign o_q_item.last   = last;

    // sample counter within the frame
    always_comb begin
        n_idx = r_idx;
        if (xfer) begin
            n_idx = last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

// ----- hdl/sfcp_queue.sv -----
// ----------------------------------------------------------------------------
// sfcp_queue
// Two-slot shift queue decoupling the front end from the byte sequencer.
// ----------------------------------------------------------------------------
module sfcp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfcp_pkg::t_item     i_item,
    input  logic                i_pop,
    output sfcp_pkg::t_item     o_head,
    output sfcp_pkg::t_q_status o_status
);

    logic            r_v0;
    logic            r_v1;
    logic            n_v0;
    logic            n_v1;
    sfcp_pkg::t_item r_s0;
    sfcp_pkg::t_item r_s1;
    sfcp_pkg::t_item n_s0;
    sfcp_pkg::t_item n_s1;

    assign o_head         = r_s0;
    assign o_status.full  = r_v1;
    assign o_status.empty = !r_v0;
    assign o_status.count = sfcp_pkg::Q_CNT_W'({1'b0, r_v0} + {1'b0, r_v1});

    // slot 0 is the head, slot 1 waits behind it
    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_s0 = r_s0;
        n_s1 = r_s1;
        if (i_pop && i_push) begin
            if (r_v1) begin
                n_s0 = r_s1;
                n_s1 = i_item;
            end else begin
                n_s0 = i_item;
            end
        end else if (i_pop) begin
            n_s0 = r_s1;
            n_v0 = r_v1;
            n_v1 = 1'b0;
        end else if (i_push) begin
            if (!r_v0) begin
                n_s0 = i_item;
                n_v0 = 1'b1;
            end else begin
                n_s1 = i_item;
                n_v1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    // payload slots, no reset
    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
        r_s1 <= n_s1;
    end

endmodule

// ----- hdl/sfcp_back.sv -----
// ----------------------------------------------------------------------------
// sfcp_back
// Byte sequencer: sends sample bytes, folds them into the crc, closes frames.
// ----------------------------------------------------------------------------
module sfcp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfcp_pkg::t_item     i_head,
    input  sfcp_pkg::t_q_status i_q_status,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_out_byte,
    output logic                o_frame_end
);

    sfcp_pkg::t_phase r_phase;
    sfcp_pkg::t_phase n_phase;
    logic [15:0]      r_crc;
    logic [15:0]      n_crc;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [7:0]       r_out_byte;
    logic [7:0]       n_out_byte;
    logic             r_out_end;
    logic             n_out_end;
    logic             load;

    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_out_end;

    // a byte is loaded when work waits and the output register is free
    assign load = !i_q_status.empty && (!r_out_valid || i_pop);

    // phase sequencer and crc update
    always_comb begin
        n_phase    = r_phase;
        n_crc      = r_crc;
        n_out_byte = r_out_byte;
        n_out_end  = r_out_end;
        o_q_pop    = 1'b0;
        if (load) begin
            case (r_phase)
                sfcp_pkg::PH_LO: begin
                    n_out_byte = i_head.sample[7:0];
                    n_out_end  = 1'b0;
                    n_crc      = sfcp_pkg::crc_fold(r_crc, i_head.sample[7:0]);
                    n_phase    = sfcp_pkg::PH_HI;
                end
                sfcp_pkg::PH_HI: begin
                    n_out_byte = i_head.sample[15:8];
                    n_out_end  = 1'b0;
                    n_crc      = sfcp_pkg::crc_fold(r_crc, i_head.sample[15:8]);
                    if (i_head.last) begin
                        n_phase = sfcp_pkg::PH_CRC_LO;
                    end else begin
                        n_phase = sfcp_pkg::PH_LO;
                        o_q_pop = 1'b1;
                    end
                end
                sfcp_pkg::PH_CRC_LO: begin
                    n_out_byte = r_crc[7:0];
                    n_out_end  = 1'b0;
                    n_phase    = sfcp_pkg::PH_CRC_HI;
                end
                sfcp_pkg::PH_CRC_HI: begin
                    n_out_byte = r_crc[15:8];
                    n_out_end  = 1'b1;
                    n_crc      = sfcp_pkg::CRC_INIT;
                    n_phase    = sfcp_pkg::PH_LO;
                    o_q_pop    = 1'b1;
                end
                default: begin
                    n_phase = sfcp_pkg::PH_LO;
                end
            endcase
        end
    end

    // output register valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sfcp_pkg::PH_LO;
            r_crc       <= sfcp_pkg::CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload, no reset
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

endmodule

// ----- hdl/scope_frame_crc16_packer.sv -----
// ----------------------------------------------------------------------------
// scope_frame_crc16_packer
// Packs frames of 16-bit samples into bytes with a trailing modbus crc-16.
// ----------------------------------------------------------------------------
//  channel   ports                        direction  width
//  sample    i_push / o_full, i_sample    in         16 signed
//  result    o_empty / i_pop, o_out_byte  out        8
//            o_frame_end                  out        1
//
//  The byte sequencer puts out one byte per cycle while bytes are popped and
//  samples wait: a sample gives two bytes, the last sample of a frame four (two data bytes, two crc bytes).
//  A two-slot queue between front and sequencer lets samples be taken while
//  bytes are still going out; push stalls only when that queue is full.
//  Synchronous reset clears crc, phase, frame counter and the valid flags of queue and output register.
//  A stalled pop holds the byte on the output ports.
// ----------------------------------------------------------------------------
module scope_frame_crc16_packer #(
    parameter int CHANNELS = sfcp_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_sample,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end
);

    sfcp_pkg::t_item     q_item;
    sfcp_pkg::t_item     q_head;
    sfcp_pkg::t_q_status q_status;
    logic                q_push;
    logic                q_pop;

    // front end: accept and classify
    sfcp_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_sample   (i_sample),
        .i_q_status (q_status),
        .o_full     (o_full),
        .o_q_push   (q_push),
        .o_q_item   (q_item)
    );

    // decoupling queue
    sfcp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (q_item),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // back end: byte sequencer
    sfcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_status  (q_status),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

    // no push into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("push into full queue");

    // no pop from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // second slot is only occupied behind a valid head
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !q_status.empty)
        else $error("queue slot order broken");

    // an accepted sample with no pop in the same cycle raises the queue count next cycle
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> (q_status.count == $past(q_status.count) + 2'd1))
        else $error("queue count did not grow on push");

endmodule
